@@ hdl/pmbd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmbd_pkg
// shared types and constants of the paged memory bus decoder
// ----------------------------------------------------------------------------
package pmbd_pkg;

  localparam int OFF_W  = 24;  // offset bits within a page
  localparam int SIZE_W = 25;  // region sizes up to 2^24 bytes

  // every region holds at least 256 bytes, so a quotient fits in 16 bits
  localparam int QUO_W   = 16;
  // floor(2^24 / size) for a size of at least 256 bytes
  localparam int RECIP_W = 17;
  localparam int PROD_W  = OFF_W + QUO_W;

  typedef enum logic [2:0] {
    OP_RD_BYTE   = 3'd0,
    OP_RD_HALF   = 3'd1,
    OP_RD_WORD   = 3'd2,
    OP_WR_BYTE   = 3'd3,
    OP_WR_HALF   = 3'd4,
    OP_WR_WORD   = 3'd5,
    OP_LOAD_BYTE = 3'd6
  } op_t;

  localparam logic [7:0] PAGE_BOOT = 8'h00;
  localparam logic [7:0] PAGE_WORK = 8'h02;
  localparam logic [7:0] PAGE_IRAM = 8'h03;
  localparam logic [7:0] PAGE_PAL  = 8'h05;
  localparam logic [7:0] PAGE_VRAM = 8'h06;
  localparam logic [7:0] PAGE_CART = 8'h08;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LANE,
    ST_MOD,
    ST_READ,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic               start;
    logic [OFF_W-1:0]   dividend;
    logic [SIZE_W-1:0]  divisor;
    logic [RECIP_W-1:0] recip;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [OFF_W-1:0] rem;
  } mod_rsp_t;

endpackage
`default_nettype wire

@@ hdl/pmbd_mod_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmbd_mod_unit
// remainder of a page offset by a region size through a reciprocal multiply
// and one correcting subtract
// ----------------------------------------------------------------------------
module pmbd_mod_unit
  import pmbd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mod_req_t req,
  output mod_rsp_t      rsp
);

  logic [2:0]         stage;
  logic               done;
  logic [OFF_W-1:0]   x_q;
  logic [SIZE_W-1:0]  n_q;
  logic [RECIP_W-1:0] m_q;
  logic [QUO_W-1:0]   q_q;
  logic [SIZE_W-1:0]  r_q;
  logic [OFF_W-1:0]   rem;

  assign rsp.done = done;
  assign rsp.rem  = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[1:0], req.start};
      done  <= stage[2];
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_q <= req.dividend;
      n_q <= req.divisor;
      m_q <= req.recip;
    end
    // quotient estimate, low by at most one
    if (stage[0]) begin
      q_q <= QUO_W'((PROD_W'(x_q) * PROD_W'(m_q)) >> OFF_W);
    end
    // partial remainder below twice the size
    if (stage[1]) begin
      r_q <= SIZE_W'(x_q) - SIZE_W'(q_q) * n_q;
    end
    if (stage[2]) begin
      rem <= OFF_W'((r_q >= n_q) ? r_q - n_q : r_q);
    end
  end

endmodule
`default_nettype wire

@@ hdl/pmbd_byte_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmbd_byte_mem
// single port byte memory holding every region, registered read
// ----------------------------------------------------------------------------
module pmbd_byte_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic [7:0]         rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ hdl/paged_memory_bus_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paged_memory_bus_decoder
// byte, halfword and word bus accesses decoded onto six paged regions that
// share one byte-wide memory
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  op, address, write_data
//  rsp      out        rsp_valid / rsp_ready  read_data
//
//  one transaction: accept, then per byte lane a decode, the offset remainder
//  unit and, on read lanes, the memory read; then the result goes into the
//  output register. unmapped lanes skip the remainder unit and the memory;
//  the memory port allows one byte per cycle
//  after reset a clearing pass zeroes the ram regions, one byte per cycle;
//  a new transaction is taken while a result waits
// ----------------------------------------------------------------------------
module paged_memory_bus_decoder
  import pmbd_pkg::*;
#(
  parameter int WORK_RAM_BYTES     = 262144,
  parameter int INTERNAL_RAM_BYTES = 32768,
  parameter int PALETTE_RAM_BYTES  = 1024,
  parameter int VIDEO_RAM_BYTES    = 131072,
  parameter int BOOT_ROM_BYTES     = 16384,
  parameter int CART_ROM_BYTES     = 4194304
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [2:0]  op,
  input  wire logic [31:0] address,
  input  wire logic [31:0] write_data,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output logic [31:0]      read_data
);

  // memory layout: ram regions first so the clearing pass is one sweep
  localparam int WORK_BASE  = 0;
  localparam int IRAM_BASE  = WORK_BASE + WORK_RAM_BYTES;
  localparam int PAL_BASE   = IRAM_BASE + INTERNAL_RAM_BYTES;
  localparam int VRAM_BASE  = PAL_BASE + PALETTE_RAM_BYTES;
  localparam int BOOT_BASE  = VRAM_BASE + VIDEO_RAM_BYTES;
  localparam int CART_BASE  = BOOT_BASE + BOOT_ROM_BYTES;
  localparam int MEM_DEPTH  = CART_BASE + CART_ROM_BYTES;
  localparam int AW         = $clog2(MEM_DEPTH);

  localparam logic [AW-1:0] CLR_LAST = AW'(BOOT_BASE - 1);

  localparam logic [SIZE_W-1:0] N_WORK = SIZE_W'(WORK_RAM_BYTES);
  localparam logic [SIZE_W-1:0] N_IRAM = SIZE_W'(INTERNAL_RAM_BYTES);
  localparam logic [SIZE_W-1:0] N_PAL  = SIZE_W'(PALETTE_RAM_BYTES);
  localparam logic [SIZE_W-1:0] N_VRAM = SIZE_W'(VIDEO_RAM_BYTES);
  localparam logic [SIZE_W-1:0] N_BOOT = SIZE_W'(BOOT_ROM_BYTES);
  localparam logic [SIZE_W-1:0] N_CART = SIZE_W'(CART_ROM_BYTES);

  // reciprocals of the region sizes, scaled by 2^24
  localparam logic [RECIP_W-1:0] R_WORK = RECIP_W'((1 << OFF_W) / WORK_RAM_BYTES);
  localparam logic [RECIP_W-1:0] R_IRAM = RECIP_W'((1 << OFF_W) / INTERNAL_RAM_BYTES);
  localparam logic [RECIP_W-1:0] R_PAL  = RECIP_W'((1 << OFF_W) / PALETTE_RAM_BYTES);
  localparam logic [RECIP_W-1:0] R_VRAM = RECIP_W'((1 << OFF_W) / VIDEO_RAM_BYTES);
  localparam logic [RECIP_W-1:0] R_BOOT = RECIP_W'((1 << OFF_W) / BOOT_ROM_BYTES);
  localparam logic [RECIP_W-1:0] R_CART = RECIP_W'((1 << OFF_W) / CART_ROM_BYTES);

  state_t state, state_next;

  // transaction registers
  logic [31:0]   addr_q;
  logic [31:0]   data_q;
  logic [1:0]    lane_q;
  logic [1:0]    last_q;
  logic          rd_q;
  logic          rom_ok_q;
  logic [31:0]   acc_q;
  logic [AW-1:0] base_q;
  logic [AW-1:0] clr_addr;

  // lane decode
  logic [31:0]        lane_addr;
  logic [7:0]         page;
  logic [OFF_W-1:0]   off;
  logic               hit;
  logic [SIZE_W-1:0]  lane_size;
  logic [RECIP_W-1:0] lane_recip;
  logic [AW-1:0]      lane_base;

  // accept-time decode
  logic [31:0] acc_addr;
  logic [1:0]  acc_last;
  logic        acc_rd;
  logic        acc_rom_ok;
  logic        acc_known;

  // control
  logic     lane_adv;
  logic     fin_load;
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  pmbd_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  pmbd_byte_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // op decode at accept: reads align down, writes keep the address
  always_comb begin
    acc_addr   = address;
    acc_last   = 2'd0;
    acc_rd     = 1'b0;
    acc_rom_ok = 1'b0;
    acc_known  = 1'b1;
    case (op_t'(op))
      OP_RD_BYTE: begin
        acc_rd = 1'b1;
      end
      OP_RD_HALF: begin
        acc_rd   = 1'b1;
        acc_last = 2'd1;
        acc_addr = address & ~32'd1;
      end
      OP_RD_WORD: begin
        acc_rd   = 1'b1;
        acc_last = 2'd3;
        acc_addr = address & ~32'd3;
      end
      OP_WR_BYTE: begin
        acc_last = 2'd0;
      end
      OP_WR_HALF: begin
        acc_last = 2'd1;
      end
      OP_WR_WORD: begin
        acc_last = 2'd3;
      end
      OP_LOAD_BYTE: begin
        acc_rom_ok = 1'b1;
      end
      default: begin
        // unused code: no access, result zero
        acc_known = 1'b0;
      end
    endcase
  end

  // each lane decodes its own byte address, wrapping over 2^32
  assign lane_addr = addr_q + {30'd0, lane_q};
  assign page      = lane_addr[31:24];
  assign off       = lane_addr[OFF_W-1:0];

  always_comb begin
    hit        = 1'b0;
    lane_size  = N_WORK;
    lane_recip = R_WORK;
    lane_base  = AW'(WORK_BASE);
    case (page)
      PAGE_BOOT: begin
        hit        = rd_q || rom_ok_q;
        lane_size  = N_BOOT;
        lane_recip = R_BOOT;
        lane_base  = AW'(BOOT_BASE);
      end
      PAGE_WORK: begin
        hit = 1'b1;
      end
      PAGE_IRAM: begin
        // hard limit, no wrap
        hit        = {1'b0, off} < N_IRAM;
        lane_size  = N_IRAM;
        lane_recip = R_IRAM;
        lane_base  = AW'(IRAM_BASE);
      end
      PAGE_PAL: begin
        hit        = 1'b1;
        lane_size  = N_PAL;
        lane_recip = R_PAL;
        lane_base  = AW'(PAL_BASE);
      end
      PAGE_VRAM: begin
        hit        = 1'b1;
        lane_size  = N_VRAM;
        lane_recip = R_VRAM;
        lane_base  = AW'(VRAM_BASE);
      end
      PAGE_CART: begin
        hit        = rd_q || rom_ok_q;
        lane_size  = N_CART;
        lane_recip = R_CART;
        lane_base  = AW'(CART_BASE);
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and outputs
  always_comb begin
    state_next       = state;
    req_ready        = 1'b0;
    lane_adv         = 1'b0;
    fin_load         = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = off;
    mod_req.divisor  = lane_size;
    mod_req.recip    = lane_recip;
    mem_we           = 1'b0;
    mem_addr         = base_q + AW'(mod_rsp.rem);
    mem_wdata        = data_q[{lane_q, 3'b000} +: 8];
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = 8'd0;
        if (clr_addr == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = acc_known ? ST_LANE : ST_FIN;
        end
      end
      ST_LANE: begin
        if (hit) begin
          mod_req.start = 1'b1;
          state_next    = ST_MOD;
        end else begin
          lane_adv = 1'b1;
        end
      end
      ST_MOD: begin
        if (mod_rsp.done) begin
          if (rd_q) begin
            state_next = ST_READ;
          end else begin
            mem_we   = 1'b1;
            lane_adv = 1'b1;
          end
        end
      end
      ST_READ: begin
        lane_adv = 1'b1;
      end
      ST_FIN: begin
        if (!rsp_valid || rsp_ready) begin
          fin_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (lane_adv) begin
      state_next = (lane_q == last_q) ? ST_FIN : ST_LANE;
    end
  end

  // transaction datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (req_valid && req_ready) begin
        addr_q   <= acc_addr;
        data_q   <= write_data;
        last_q   <= acc_last;
        rd_q     <= acc_rd;
        rom_ok_q <= acc_rom_ok;
        lane_q   <= 2'd0;
        acc_q    <= 32'd0;
      end
      if (state == ST_LANE && hit) begin
        base_q <= lane_base;
      end
      if (state == ST_READ) begin
        acc_q[{lane_q, 3'b000} +: 8] <= mem_rdata;
      end
      if (lane_adv) begin
        lane_q <= lane_q + 1'b1;
      end
    end
  end

  // output register parts the result from the engine
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin_load) begin
      rsp_valid <= 1'b1;
      read_data <= acc_q;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // bus writes never reach the rom area
  a_no_rom_write: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state != ST_CLEAR && !rom_ok_q) |-> (mem_addr < AW'(BOOT_BASE)))
    else $error("bus write reached rom area");

  // modulo results only show up while a lane waits for them
  a_mod_when_waiting: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> (state == ST_MOD))
    else $error("modulo unit finished outside a lane");

  // a finished offset always lies inside its region
  a_rem_in_region: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD && mod_rsp.done) |-> ({1'b0, mod_rsp.rem} < mod_req.divisor))
    else $error("offset outside its region");

  // a read lane captures data in the cycle after the memory address is set
  a_read_follows_mod: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> ($past(state) == ST_MOD && $past(mod_rsp.done)))
    else $error("read lane without a finished address");

endmodule
`default_nettype wire

@@ sim/paged_memory_bus_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_memory_bus_decoder_tb
// drives bus reads, writes and image loads into the paged decoder and checks
// every read_data against a typed value or a byte-level shadow of all six regions
// ----------------------------------------------------------------------------
module paged_memory_bus_decoder_tb;
  import pmbd_pkg::*;

  // region sizes, kept at the block defaults
  localparam int unsigned WORK_RAM_SIZE     = 262144;
  localparam int unsigned INTERNAL_RAM_SIZE = 32768;
  localparam int unsigned PALETTE_RAM_SIZE  = 1024;
  localparam int unsigned VIDEO_RAM_SIZE    = 131072;
  localparam int unsigned BOOT_ROM_SIZE     = 16384;
  localparam int unsigned CART_ROM_SIZE     = 4194304;

  // op code the block leaves unused
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam int RANDOM_PER_PHASE = 500;
  localparam int DRAIN_CYCLES     = 100;
  // clearing pass plus every transaction at its slowest, taken several times
  localparam int TIMEOUT_NS       = 16_000_000;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] addr;
    logic [31:0] data;
    bit          fixed;   // read value typed in below
    logic [31:0] value;
  } access_row_t;

  typedef struct packed {
    bit          fixed;
    logic [31:0] value;
  } typed_read_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [2:0]  op = 3'd0;
  logic [31:0] address = 32'd0;
  logic [31:0] write_data = 32'd0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [31:0] read_data;

  // shadow of every mapped byte, keyed by {page, offset inside the region}
  logic [7:0]  shadow_mem [logic [31:0]];
  // rom bytes already loaded by the stimulus, tracked at issue time
  bit          rom_filled [logic [31:0]];
  logic [31:0] pending_reads [$];
  typed_read_t typed_reads [$];

  int          error_count = 0;
  int          issued_count = 0;
  int          completed_count = 0;
  int          req_idle_pct = 10;
  int          rsp_idle_pct = 71;
  logic [31:0] last_addr = 32'd0;

  // directed transactions: extremes, every op, wraps, ignored writes
  access_row_t directed_rows [25] = '{
    '{OP_RD_WORD,   32'h0200_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{OP_RD_WORD,   32'h0300_7FFC, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{OP_WR_WORD,   32'h0200_0000, 32'hDEAD_BEEF, 1'b1, 32'h0000_0000},
    '{OP_RD_WORD,   32'h0200_0000, 32'h0000_0000, 1'b1, 32'hDEAD_BEEF},
    '{OP_RD_HALF,   32'h0200_0003, 32'h0000_0000, 1'b1, 32'h0000_DEAD},
    '{OP_RD_BYTE,   32'h0200_0001, 32'h0000_0000, 1'b1, 32'h0000_00BE},
    // unaligned word crossing from work ram into internal ram
    '{OP_WR_WORD,   32'h02FF_FFFE, 32'h1122_3344, 1'b1, 32'h0000_0000},
    '{OP_RD_WORD,   32'h0300_0000, 32'h0000_0000, 1'b1, 32'h0000_1122},
    '{OP_RD_HALF,   32'h0203_FFFE, 32'h0000_0000, 1'b1, 32'h0000_3344},
    // internal ram past its end
    '{OP_WR_BYTE,   32'h0300_8000, 32'h0000_00AA, 1'b1, 32'h0000_0000},
    '{OP_RD_BYTE,   32'h0300_8000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    // bus write to boot rom is dropped
    '{OP_WR_WORD,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{OP_LOAD_BYTE, 32'h0000_0000, 32'h0000_005A, 1'b1, 32'h0000_0000},
    '{OP_LOAD_BYTE, 32'h0000_0001, 32'h0000_00A5, 1'b1, 32'h0000_0000},
    '{OP_LOAD_BYTE, 32'h0000_4002, 32'h0000_003C, 1'b1, 32'h0000_0000},
    '{OP_LOAD_BYTE, 32'h0000_0003, 32'hFFFF_FFC3, 1'b1, 32'h0000_0000},
    '{OP_RD_WORD,   32'h0000_0000, 32'h0000_0000, 1'b1, 32'hC33C_A55A},
    '{OP_LOAD_BYTE, 32'h08FF_FFFE, 32'h0000_0077, 1'b1, 32'h0000_0000},
    '{OP_LOAD_BYTE, 32'h08FF_FFFF, 32'h0000_0088, 1'b1, 32'h0000_0000},
    '{OP_RD_HALF,   32'h083F_FFFF, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{OP_UNUSED,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    // unmapped top page wrapping into boot rom, all lanes dropped
    '{OP_WR_WORD,   32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 32'h0000_0000},
    '{OP_RD_WORD,   32'h0000_4000, 32'h0000_0000, 1'b0, 32'h0000_0000},
    // palette halfword wrapping at the region end
    '{OP_WR_HALF,   32'h0500_03FF, 32'h0000_BEEF, 1'b1, 32'h0000_0000},
    '{OP_RD_HALF,   32'h0500_0000, 32'h0000_0000, 1'b0, 32'h0000_0000}
  };

  paged_memory_bus_decoder #(
    .WORK_RAM_BYTES    (WORK_RAM_SIZE),
    .INTERNAL_RAM_BYTES(INTERNAL_RAM_SIZE),
    .PALETTE_RAM_BYTES (PALETTE_RAM_SIZE),
    .VIDEO_RAM_BYTES   (VIDEO_RAM_SIZE),
    .BOOT_ROM_BYTES    (BOOT_ROM_SIZE),
    .CART_ROM_BYTES    (CART_ROM_SIZE)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .op        (op),
    .address   (address),
    .write_data(write_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .read_data (read_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hard limit on the whole run
  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int access_lanes(input logic [2:0] o);
    case (o)
      OP_RD_HALF, OP_WR_HALF: access_lanes = 2;
      OP_RD_WORD, OP_WR_WORD: access_lanes = 4;
      default:                access_lanes = 1;
    endcase
  endfunction

  function automatic int unsigned region_span(input logic [7:0] page);
    case (page)
      PAGE_BOOT: region_span = BOOT_ROM_SIZE;
      PAGE_WORK: region_span = WORK_RAM_SIZE;
      PAGE_IRAM: region_span = INTERNAL_RAM_SIZE;
      PAGE_PAL:  region_span = PALETTE_RAM_SIZE;
      PAGE_VRAM: region_span = VIDEO_RAM_SIZE;
      PAGE_CART: region_span = CART_ROM_SIZE;
      default:   region_span = 32'h0100_0000;
    endcase
  endfunction

  // decode one byte address to its shadow key; 0 when nothing is there
  function automatic bit map_byte(input logic [31:0] a, input bit rom_ok,
                                  output logic [31:0] key);
    logic [7:0]  page;
    logic [23:0] off;
    page = a[31:24];
    off  = a[23:0];
    key  = {page, 24'(off % region_span(page))};
    case (page)
      PAGE_BOOT, PAGE_CART:            map_byte = rom_ok;
      PAGE_WORK, PAGE_PAL, PAGE_VRAM:  map_byte = 1'b1;
      // internal ram has a hard end instead of a wrap
      PAGE_IRAM:                       map_byte = (off < INTERNAL_RAM_SIZE);
      default:                         map_byte = 1'b0;
    endcase
  endfunction

  // one bus transaction against the shadow; returns the read value
  function automatic logic [31:0] apply_access(input logic [2:0] o,
                                               input logic [31:0] a,
                                               input logic [31:0] d);
    int          lanes;
    logic [31:0] base;
    logic [31:0] key;
    logic [31:0] rd;
    lanes = access_lanes(o);
    rd    = 32'd0;
    case (o)
      OP_RD_BYTE, OP_RD_HALF, OP_RD_WORD: begin
        base = a & ~32'(lanes - 1);
        for (int i = 0; i < lanes; i++) begin
          if (map_byte(base + 32'(i), 1'b1, key) && shadow_mem.exists(key))
            rd[8*i +: 8] = shadow_mem[key];
        end
      end
      OP_WR_BYTE, OP_WR_HALF, OP_WR_WORD: begin
        // each lane decoded on its own, rom dropped
        for (int i = 0; i < lanes; i++) begin
          if (map_byte(a + 32'(i), 1'b0, key))
            shadow_mem[key] = d[8*i +: 8];
        end
      end
      OP_LOAD_BYTE: begin
        if (map_byte(a, 1'b1, key))
          shadow_mem[key] = d[7:0];
      end
      default: ;
    endcase
    apply_access = rd;
  endfunction

  // a read that would touch a never-loaded rom byte; gives that byte address
  function automatic bit rom_gap(input logic [2:0] o, input logic [31:0] a,
                                 output logic [31:0] miss);
    int          lanes;
    logic [31:0] base;
    logic [31:0] lane_addr;
    logic [31:0] key;
    lanes = access_lanes(o);
    base  = a & ~32'(lanes - 1);
    miss  = a;
    if (o != OP_RD_BYTE && o != OP_RD_HALF && o != OP_RD_WORD)
      return 1'b0;
    for (int i = 0; i < lanes; i++) begin
      lane_addr = base + 32'(i);
      if (lane_addr[31:24] == PAGE_BOOT || lane_addr[31:24] == PAGE_CART) begin
        void'(map_byte(lane_addr, 1'b1, key));
        if (!rom_filled.exists(key)) begin
          miss = lane_addr;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // mostly mapped pages, offsets near the region edges, random, or aliased past them
  function automatic logic [31:0] random_address();
    logic [7:0]  page;
    logic [23:0] off;
    int unsigned span;
    if ($urandom_range(99) < 15) begin
      page = 8'($urandom);
    end else begin
      case ($urandom_range(5))
        0:       page = PAGE_BOOT;
        1:       page = PAGE_WORK;
        2:       page = PAGE_IRAM;
        3:       page = PAGE_PAL;
        4:       page = PAGE_VRAM;
        default: page = PAGE_CART;
      endcase
    end
    span = region_span(page);
    case ($urandom_range(3))
      0:       off = 24'($urandom_range(63));
      1:       off = 24'(span - 1 - $urandom_range(63));
      2:       off = 24'($urandom);
      default: off = 24'(($urandom & ~(span - 1)) | $urandom_range(63));
    endcase
    return {page, off};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %08h want %08h", $realtime, what, got, want);
    error_count++;
  endtask

  // present one transaction and hold it until the block takes it
  task automatic drive_access(input logic [2:0] o, input logic [31:0] a,
                              input logic [31:0] d, input bit fixed,
                              input logic [31:0] value);
    logic [31:0] key;
    bit          taken;
    if (o == OP_LOAD_BYTE && map_byte(a, 1'b1, key))
      rom_filled[key] = 1'b1;
    typed_reads.push_back('{fixed, value});
    issued_count++;
    while ($urandom_range(99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    op         <= o;
    address    <= a;
    write_data <= d;
    // ready is stable from the falling edge to the next rising edge
    do begin
      @(negedge clk);
      taken = req_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic random_access();
    logic [2:0]  o;
    logic [31:0] a;
    logic [31:0] d;
    logic [31:0] miss;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 45)
      o = 3'($urandom_range(OP_RD_WORD, OP_RD_BYTE));
    else if (pick < 80)
      o = 3'($urandom_range(OP_WR_WORD, OP_WR_BYTE));
    else if (pick < 95)
      o = OP_LOAD_BYTE;
    else
      o = OP_UNUSED;
    // revisit the last address often so reads see what was just written
    if ($urandom_range(99) < 35)
      a = last_addr;
    else
      a = random_address();
    d = $urandom;
    // an unloaded rom byte is loaded first instead of read
    if (rom_gap(o, a, miss)) begin
      o = OP_LOAD_BYTE;
      a = miss;
    end
    last_addr = a;
    drive_access(o, a, d, 1'b0, 32'd0);
  endtask

  // accepted transactions update the shadow in order
  always @(posedge clk) begin
    logic [31:0] predicted;
    typed_read_t pin;
    if (!rst && req_valid && req_ready) begin
      predicted = apply_access(op, address, write_data);
      pin = typed_reads.pop_front();
      pending_reads.push_back(pin.fixed ? pin.value : predicted);
    end
  end

  // result side: random back-pressure and the check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      completed_count++;
      if (pending_reads.size() == 0)
        report_mismatch("unexpected read_data", read_data, 32'd0);
      else if (read_data !== pending_reads[0])
        report_mismatch("read_data", read_data, pending_reads.pop_front());
      else
        void'(pending_reads.pop_front());
    end
    rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender seldom idle, receiver stalls often
    req_idle_pct = 10;
    rsp_idle_pct = 71;
    foreach (directed_rows[i])
      drive_access(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                   directed_rows[i].fixed, directed_rows[i].value);
    repeat (RANDOM_PER_PHASE) random_access();

    // let the block drain completely before the next phase
    req_valid <= 1'b0;
    while (completed_count != issued_count) @(posedge clk);

    req_idle_pct = 71;
    rsp_idle_pct = 10;
    repeat (RANDOM_PER_PHASE) random_access();

    req_idle_pct = 0;
    rsp_idle_pct = 0;
    repeat (RANDOM_PER_PHASE) random_access();

    req_valid <= 1'b0;
    while (completed_count != issued_count) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_reads.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
